[hdl/sbma_pkg.sv]
// Shared types and constants for the sorted bucket mean aggregator.
// No dependencies; sbma_front, sbma_back and the top level refer to this package by scoped name.
`timescale 1ns / 1ps

package sbma_pkg;

    localparam int CNT_W    = 32;  // total cell count
    localparam int DEV_W    = 33;  // signed Q24.8 deviation
    localparam int MEAN_W   = 40;  // unsigned Q32.8 count mean
    localparam int IDX_W    = 3;   // bucket index on the result port
    localparam int FRAC_W   = 8;   // fraction bits of Q formats
    localparam int KEPT_W   = 4;   // kept-bucket register
    localparam int REC_W    = CNT_W + DEV_W;

    localparam logic [KEPT_W-1:0] KEPT_RESET   = 4'd4;
    // deviation forced onto low-count records (-2.0 in Q24.8)
    localparam logic signed [DEV_W-1:0] REPLACED_DEV = -33'sd512;

    // handoff of a full batch from loader to sorter
    typedef struct packed {
        logic              valid;
        logic [KEPT_W-1:0] kept;
    } job_t;

    // sorter status back to loader
    typedef struct packed {
        logic ack;   // job taken
        logic done;  // all results issued, store may be refilled
        logic busy;  // sorter owns the store
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_DIV,
        ST_DWAIT,
        ST_OUT
    } back_state_t;

endpackage

[hdl/sbma_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sbma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/sbma_div.sv]
// Divider by the constant bucket size: multiply by a scaled reciprocal, 16 reciprocal
// bits a cycle, then keep the high bits. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sbma_div #(
    parameter int DW      = 47,
    parameter int DIVISOR = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient
);

    // floor(x / d) == floor(x * ceil(2^(DW+L) / d) / 2^(DW+L)) for x < 2^DW, 2^L >= d
    localparam int LW  = $clog2(DIVISOR);
    localparam int SH  = DW + LW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int CH  = 16;
    localparam int NCH = (DW + CH) / CH;   // chunks covering DW+1 reciprocal bits
    localparam int MW  = NCH * CH;
    localparam int PRW = DW + CH;
    localparam int ACW = DW + MW;
    localparam int CW  = $clog2(NCH + 1);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]  x_reg, x_next;
    logic [MW-1:0]  m_reg, m_next;
    logic [ACW-1:0] acc_reg, acc_next;
    logic [PRW-1:0] prod;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        prod      = PRW'(x_reg) * PRW'(m_reg[MW-1 -: CH]);
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = dividend;
            m_next    = RECIP_M;
            acc_next  = '0;
        end else if (busy_reg) begin
            // Horner step, most significant reciprocal chunk first
            acc_next = (acc_reg << CH) + ACW'(prod);
            m_next   = m_reg << CH;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NCH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = DW'(acc_reg >> SH);

endmodule

[hdl/sbma_front.sv]
// Loader: accepts record beats, writes them to the record store, hands a full batch on.
// Depends on sbma_pkg.
`timescale 1ns / 1ps

module sbma_front #(
    parameter int N  = 64,
    parameter int AW = (N > 1) ? $clog2(N) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbma_pkg::CNT_W-1:0]    s_total_count,
    input  logic [sbma_pkg::DEV_W-1:0]    s_circuit_stdev,
    input  logic [sbma_pkg::KEPT_W-1:0]   kept,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [sbma_pkg::REC_W-1:0]    wr_data,
    output sbma_pkg::job_t                job,
    input  sbma_pkg::rsp_t                rsp
);

    logic [AW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         jv_reg, jv_next;
    logic [sbma_pkg::KEPT_W-1:0]  jk_reg, jk_next;
    logic                         accept;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && !busy_reg;
    assign wr_en   = accept;
    assign wr_addr = cnt_reg;
    assign wr_data = {s_total_count, s_circuit_stdev};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        jv_next   = jv_reg;
        jk_next   = jk_reg;
        if (rsp.ack) begin
            jv_next = 1'b0;
        end
        if (rsp.done) begin
            busy_next = 1'b0;
        end
        // last beat of a batch: freeze loading until the sorter is through
        if (accept) begin
            if (cnt_reg == AW'(N - 1)) begin
                cnt_next  = '0;
                busy_next = 1'b1;
                jv_next   = 1'b1;
                jk_next   = kept;
            end else begin
                cnt_next = cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            jv_reg   <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            jv_reg   <= jv_next;
        end
        jk_reg <= jk_next;
    end

    assign job.valid = jv_reg;
    assign job.kept  = jk_reg;

endmodule

[hdl/sbma_back.sv]
// Sorter: streams the store in ascending order by repeated min scans, sums buckets,
// drives the divider and the result register. Depends on sbma_pkg.
`timescale 1ns / 1ps

module sbma_back #(
    parameter int BS   = 8,
    parameter int BC   = 8,
    parameter int N    = BS * BC,
    parameter int AW   = (N > 1) ? $clog2(N) : 1,
    parameter int BW   = (BC > 1) ? $clog2(BC) : 1,
    parameter int SUMW = sbma_pkg::DEV_W + $clog2(BS),
    parameter int DW   = SUMW + sbma_pkg::FRAC_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbma_pkg::job_t                job,
    output sbma_pkg::rsp_t                rsp,
    // record store read
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [sbma_pkg::REC_W-1:0]    rd_data,
    // count mean store
    output logic                          mean_we,
    output logic [BW-1:0]                 mean_waddr,
    output logic [sbma_pkg::MEAN_W-1:0]   mean_wdata,
    output logic                          mean_re,
    output logic [BW-1:0]                 mean_raddr,
    input  logic [sbma_pkg::MEAN_W-1:0]   mean_rdata,
    // divider
    output logic                          div_start,
    output logic [DW-1:0]                 div_dividend,
    input  logic                          div_done,
    input  logic [DW-1:0]                 div_quotient,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbma_pkg::IDX_W-1:0]    m_bucket_index,
    output logic [sbma_pkg::MEAN_W-1:0]   m_count_mean,
    output logic [sbma_pkg::DEV_W-1:0]    m_stdev_mean,
    output logic                          m_last
);

    localparam int KW = $clog2(BC + 1);
    localparam int PW = (BS > 1) ? $clog2(BS) : 1;
    localparam int KY = sbma_pkg::DEV_W;

    sbma_pkg::back_state_t state_reg, state_next;

    logic                               pass_reg, pass_next;
    logic                               hl_reg, hl_next;
    logic [KY-1:0]                      lkey_reg, lkey_next;
    logic [AW-1:0]                      lidx_reg, lidx_next;
    logic                               bf_reg, bf_next;
    logic [KY-1:0]                      bkey_reg, bkey_next;
    logic [AW-1:0]                      bidx_reg, bidx_next;
    logic signed [KY-1:0]               bval_reg, bval_next;
    logic [AW:0]                        j_reg, j_next;
    logic                               vd_reg, vd_next;
    logic [AW-1:0]                      idd_reg, idd_next;
    logic [PW-1:0]                      pos_reg, pos_next;
    logic [BW-1:0]                      bkt_reg, bkt_next;
    logic signed [SUMW-1:0]             sum_reg, sum_next;
    logic [sbma_pkg::CNT_W-1:0]         thr_reg, thr_next;
    logic [KW-1:0]                      kept_reg, kept_next;
    logic                               neg_reg, neg_next;
    logic [sbma_pkg::DEV_W-1:0]         dev_reg, dev_next;
    logic                               mv_reg, mv_next;
    logic [sbma_pkg::IDX_W-1:0]         mi_reg, mi_next;
    logic [sbma_pkg::MEAN_W-1:0]        mc_reg, mc_next;
    logic [sbma_pkg::DEV_W-1:0]         ms_reg, ms_next;
    logic                               ml_reg, ml_next;

    // element decode of the read-back record
    logic [sbma_pkg::CNT_W-1:0]         e_cnt;
    logic signed [sbma_pkg::DEV_W-1:0]  e_dev;
    logic signed [sbma_pkg::DEV_W-1:0]  e_val;
    logic [KY-1:0]                      e_key;
    logic                               above, below;
    logic signed [SUMW-1:0]             val_ext, sum_add;
    logic [SUMW-1:0]                    mag;

    always_comb begin
        e_cnt = rd_data[sbma_pkg::REC_W-1:sbma_pkg::DEV_W];
        e_dev = $signed(rd_data[sbma_pkg::DEV_W-1:0]);
        if (pass_reg && (e_cnt < thr_reg)) begin
            e_dev = sbma_pkg::REPLACED_DEV;
        end
        // second pass orders deviations: flip sign bit for an unsigned compare
        e_val = pass_reg ? e_dev : $signed({1'b0, e_cnt});
        e_key = pass_reg ? {~e_dev[KY-1], e_dev[KY-2:0]} : {1'b0, e_cnt};
        above = !hl_reg || (e_key > lkey_reg) ||
                ((e_key == lkey_reg) && (idd_reg > lidx_reg));
        below = !bf_reg || (e_key < bkey_reg);
        val_ext = SUMW'(bval_reg);
        sum_add = sum_reg + val_ext;
        mag     = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        hl_next    = hl_reg;
        lkey_next  = lkey_reg;
        lidx_next  = lidx_reg;
        bf_next    = bf_reg;
        bkey_next  = bkey_reg;
        bidx_next  = bidx_reg;
        bval_next  = bval_reg;
        j_next     = j_reg;
        vd_next    = 1'b0;
        idd_next   = idd_reg;
        pos_next   = pos_reg;
        bkt_next   = bkt_reg;
        sum_next   = sum_reg;
        thr_next   = thr_reg;
        kept_next  = kept_reg;
        neg_next   = neg_reg;
        dev_next   = dev_reg;
        mv_next    = mv_reg && !m_ready;
        mi_next    = mi_reg;
        mc_next    = mc_reg;
        ms_next    = ms_reg;
        ml_next    = ml_reg;

        rsp.ack      = 1'b0;
        rsp.done     = 1'b0;
        rsp.busy     = (state_reg != sbma_pkg::ST_IDLE);
        rd_en        = 1'b0;
        rd_addr      = j_reg[AW-1:0];
        mean_we      = 1'b0;
        mean_waddr   = bkt_reg;
        mean_wdata   = div_quotient[sbma_pkg::MEAN_W-1:0];
        mean_re      = 1'b0;
        mean_raddr   = bkt_reg;
        div_start    = 1'b0;
        div_dividend = pass_reg ? DW'(mag) : {sum_reg, {sbma_pkg::FRAC_W{1'b0}}};

        case (state_reg)
            sbma_pkg::ST_IDLE: begin
                if (job.valid) begin
                    rsp.ack   = 1'b1;
                    kept_next = (int'(job.kept) >= BC) ? KW'(BC) : KW'(job.kept);
                    pass_next = 1'b0;
                    hl_next   = 1'b0;
                    bf_next   = 1'b0;
                    j_next    = '0;
                    pos_next  = '0;
                    bkt_next  = '0;
                    sum_next  = '0;
                    thr_next  = '0;
                    state_next = sbma_pkg::ST_SCAN;
                end
            end
            // one pass over the store: smallest (key, index) above the last pick
            sbma_pkg::ST_SCAN: begin
                if (j_reg < (AW+1)'(N)) begin
                    rd_en    = 1'b1;
                    vd_next  = 1'b1;
                    idd_next = j_reg[AW-1:0];
                    j_next   = j_reg + (AW+1)'(1);
                end
                if (vd_reg) begin
                    if (above && below) begin
                        bf_next   = 1'b1;
                        bkey_next = e_key;
                        bidx_next = idd_reg;
                        bval_next = e_val;
                    end
                    if (idd_reg == AW'(N - 1)) begin
                        state_next = sbma_pkg::ST_PICK;
                    end
                end
            end
            sbma_pkg::ST_PICK: begin
                lkey_next = bkey_reg;
                lidx_next = bidx_reg;
                hl_next   = 1'b1;
                bf_next   = 1'b0;
                j_next    = '0;
                sum_next  = sum_add;
                if (pos_reg == PW'(BS - 1)) begin
                    pos_next = '0;
                    // threshold: last count of the highest dropped bucket
                    if (!pass_reg && (kept_reg != KW'(BC)) &&
                        ((KW+1)'(bkt_reg) + (KW+1)'(kept_reg) == (KW+1)'(BC - 1))) begin
                        thr_next = bval_reg[sbma_pkg::CNT_W-1:0];
                    end
                    state_next = sbma_pkg::ST_DIV;
                end else begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = sbma_pkg::ST_SCAN;
                end
            end
            sbma_pkg::ST_DIV: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUMW-1];
                mean_re    = pass_reg;
                state_next = sbma_pkg::ST_DWAIT;
            end
            sbma_pkg::ST_DWAIT: begin
                if (div_done) begin
                    sum_next = '0;
                    if (!pass_reg) begin
                        mean_we = 1'b1;
                        if (bkt_reg == BW'(BC - 1)) begin
                            pass_next = 1'b1;
                            bkt_next  = '0;
                            hl_next   = 1'b0;
                        end else begin
                            bkt_next = bkt_reg + BW'(1);
                        end
                        state_next = sbma_pkg::ST_SCAN;
                    end else begin
                        dev_next = neg_reg ?
                            sbma_pkg::DEV_W'(~div_quotient[sbma_pkg::DEV_W-1:0] +
                                             sbma_pkg::DEV_W'(1)) :
                            div_quotient[sbma_pkg::DEV_W-1:0];
                        state_next = sbma_pkg::ST_OUT;
                    end
                end
            end
            sbma_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    mi_next = sbma_pkg::IDX_W'(bkt_reg);
                    mc_next = mean_rdata;
                    ms_next = dev_reg;
                    ml_next = (bkt_reg == BW'(BC - 1));
                    if (bkt_reg == BW'(BC - 1)) begin
                        rsp.done   = 1'b1;
                        state_next = sbma_pkg::ST_IDLE;
                    end else begin
                        bkt_next   = bkt_reg + BW'(1);
                        state_next = sbma_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = sbma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbma_pkg::ST_IDLE;
            vd_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            vd_reg    <= vd_next;
            mv_reg    <= mv_next;
        end
        pass_reg <= pass_next;
        hl_reg   <= hl_next;
        lkey_reg <= lkey_next;
        lidx_reg <= lidx_next;
        bf_reg   <= bf_next;
        bkey_reg <= bkey_next;
        bidx_reg <= bidx_next;
        bval_reg <= bval_next;
        j_reg    <= j_next;
        idd_reg  <= idd_next;
        pos_reg  <= pos_next;
        bkt_reg  <= bkt_next;
        sum_reg  <= sum_next;
        thr_reg  <= thr_next;
        kept_reg <= kept_next;
        neg_reg  <= neg_next;
        dev_reg  <= dev_next;
        mi_reg   <= mi_next;
        mc_reg   <= mc_next;
        ms_reg   <= ms_next;
        ml_reg   <= ml_next;
    end

    assign m_valid        = mv_reg;
    assign m_bucket_index = mi_reg;
    assign m_count_mean   = mc_reg;
    assign m_stdev_mean   = ms_reg;
    assign m_last         = ml_reg;

endmodule

[hdl/sorted_bucket_mean_aggregator.sv]
// Top level of the sorted bucket mean aggregator: config register, stores, loader,
// sorter and divider. Depends on sbma_pkg, sbma_ram, sbma_div, sbma_front, sbma_back.
`timescale 1ns / 1ps

// Records load at one beat per cycle into a BUCKET_SIZE*BUCKET_COUNT entry store
// (N entries). The beat that fills the store starts the sorter and s_ready drops
// until its last result has been issued. The sorter orders the store by repeated
// min scans over the store's single read port, once for the counts and once for
// the deviations; each bucket mean then takes a divide by reciprocal
// multiplication. There is no clearing pass; the store is only read once full.

module sorted_bucket_mean_aggregator #(
    parameter int BUCKET_SIZE  = 8,
    parameter int BUCKET_COUNT = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sbma_pkg::KEPT_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbma_pkg::CNT_W-1:0]    s_total_count,
    input  logic signed [sbma_pkg::DEV_W-1:0] s_circuit_stdev,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbma_pkg::IDX_W-1:0]    m_bucket_index,
    output logic [sbma_pkg::MEAN_W-1:0]   m_count_mean,
    output logic signed [sbma_pkg::DEV_W-1:0] m_stdev_mean,
    output logic                          m_last
);

    localparam int N    = BUCKET_SIZE * BUCKET_COUNT;
    localparam int AW   = (N > 1) ? $clog2(N) : 1;
    localparam int BW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SUMW = sbma_pkg::DEV_W + $clog2(BUCKET_SIZE);
    localparam int DW   = SUMW + sbma_pkg::FRAC_W;

    logic [sbma_pkg::KEPT_W-1:0] kept_reg;

    // kept-bucket register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= sbma_pkg::KEPT_RESET;
        end else if (cfg_we) begin
            kept_reg <= cfg_wdata;
        end
    end

    sbma_pkg::job_t              job;
    sbma_pkg::rsp_t              rsp;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [sbma_pkg::REC_W-1:0]  wr_data, rd_data;
    logic                        mean_we, mean_re;
    logic [BW-1:0]               mean_waddr, mean_raddr;
    logic [sbma_pkg::MEAN_W-1:0] mean_wdata, mean_rdata;
    logic                        div_start, div_done;
    logic [DW-1:0]               div_dividend, div_quotient;
    logic [sbma_pkg::DEV_W-1:0]  stdev_bits;

    sbma_ram #(.WIDTH(sbma_pkg::REC_W), .DEPTH(N)) u_rec_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sbma_ram #(.WIDTH(sbma_pkg::MEAN_W), .DEPTH(BUCKET_COUNT)) u_mean_ram (
        .aclk  (aclk),
        .we    (mean_we),
        .waddr (mean_waddr),
        .wdata (mean_wdata),
        .re    (mean_re),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    sbma_div #(.DW(DW), .DIVISOR(BUCKET_SIZE)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    sbma_front #(.N(N)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_total_count   (s_total_count),
        .s_circuit_stdev (s_circuit_stdev),
        .kept            (kept_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .job             (job),
        .rsp             (rsp)
    );

    sbma_back #(.BS(BUCKET_SIZE), .BC(BUCKET_COUNT)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job            (job),
        .rsp            (rsp),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .mean_we        (mean_we),
        .mean_waddr     (mean_waddr),
        .mean_wdata     (mean_wdata),
        .mean_re        (mean_re),
        .mean_raddr     (mean_raddr),
        .mean_rdata     (mean_rdata),
        .div_start      (div_start),
        .div_dividend   (div_dividend),
        .div_done       (div_done),
        .div_quotient   (div_quotient),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .m_count_mean   (m_count_mean),
        .m_stdev_mean   (stdev_bits),
        .m_last         (m_last)
    );

    assign m_stdev_mean = $signed(stdev_bits);

`ifndef NO_ASSERTIONS
    // the loader must not overwrite the store while the sorter reads it
    a_no_load_while_sorting: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.busy |-> !s_ready)
        else $error("record beat accepted while sorter owns the store");

    // a pending batch is only ever handed over with loading frozen
    a_job_implies_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        job.valid |-> !s_ready)
        else $error("batch handoff pending while loader still accepts");

    // the final result of a run carries the top bucket number
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_bucket_index == sbma_pkg::IDX_W'(BUCKET_COUNT - 1)))
        else $error("last flag on wrong bucket");
`endif

endmodule
